// ===== sv/ffha_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffha_pkg
// shared codes for the first-fit heap allocator
// ----------------------------------------------------------------------------
package ffha_pkg;
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_NOMEM   = 2'd1;
   localparam logic [1:0] ST_UNKNOWN = 2'd2;

   localparam logic CSR_HEAP_BASE = 1'b0;
   localparam logic CSR_HEAP_SIZE = 1'b1;

   typedef struct packed {
      logic [31:0] address;
      logic [1:0]  status;
   } rsp_type;
endpackage

// ===== sv/first_fit_heap_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// first-fit heap manager with block split on allocate and merge on free
// ----------------------------------------------------------------------------
// channel | dir | tdata fields (lsb first)                  | tuser
// req     | in  | request_size[31:0], free_address[63:32]   | opcode
// rsp     | out | address[31:0], status[33:32], pad to 40   | -
// csr     | in  | index 0 heap_base, 1 heap_size            | -
//
// one transaction at a time; req_tready is low while a request is worked
// an allocate walks the list from entry 0 and takes the first free block that
// fits; a free walks to the block, then runs the merge walk over the whole
// list, each step passing S_MREAD, S_MCUR, S_MNXT and S_MCHK, and S_SPLIT as
// well when two blocks merge; the block table port (one read and one write a
// cycle) paces these walks
// after reset or a csr write a clearing pass over all MAX_BLOCKS entries rebuilds
// the table; the result waits in an output register until taken while the
// next request is already worked
module first_fit_heap_allocator #(
   parameter int MAX_BLOCKS   = 64,
   parameter int HEADER_BYTES = 12
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // request_size, free_address
   input  logic        req_tuser,   // opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // address, status, zero pad
   input  logic        csr_wen,
   input  logic        csr_index,
   input  logic [31:0] csr_wdata
);
   import ffha_pkg::*;

   localparam int IW = $clog2(MAX_BLOCKS);
   localparam int LW = IW + 1;
   localparam logic [LW-1:0] END_MARK = LW'(MAX_BLOCKS);
   localparam int WALK_LIMIT = 2 * MAX_BLOCKS + 2;
   localparam int SW = $clog2(WALK_LIMIT + 1);
   localparam logic [31:0] HDR = 32'(HEADER_BYTES);

   // state codes
   localparam logic [3:0] S_CLEAR  = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_AREAD  = 4'd2;
   localparam logic [3:0] S_ACHK   = 4'd3;
   localparam logic [3:0] S_FREAD  = 4'd4;
   localparam logic [3:0] S_FCHK   = 4'd5;
   localparam logic [3:0] S_MREAD  = 4'd6;
   localparam logic [3:0] S_MCUR   = 4'd7;
   localparam logic [3:0] S_MNXT   = 4'd8;
   localparam logic [3:0] S_MCHK   = 4'd9;
   localparam logic [3:0] S_DONE   = 4'd10;
   localparam logic [3:0] S_SPLIT  = 4'd11;

   // block table: start, length, free, successor per entry
   typedef struct packed {
      logic [31:0]   start;
      logic [31:0]   length;
      logic          free;
      logic [LW-1:0] succ;
   } blk_type;

   blk_type mem [MAX_BLOCKS];
   blk_type rd_ff;
   logic [MAX_BLOCKS-1:0] used_ff, used_in;

   logic [3:0]    state_ff, state_in;
   logic [IW-1:0] clr_ff, clr_in;
   logic [31:0]   base_ff, base_in, size_ff, size_in;
   logic          op_ff, op_in;
   logic [32:0]   rsize_ff, rsize_in;
   logic [31:0]   faddr_ff, faddr_in;
   logic [LW-1:0] cur_ff, cur_in, nx_ff, nx_in;
   logic [SW-1:0] steps_ff, steps_in;
   blk_type       cb_ff, cb_in;
   rsp_type       res_ff, res_in;
   rsp_type       rsp_ff, rsp_in;
   logic          rv_ff, rv_in;

   // memory port controls
   logic          we;
   logic [IW-1:0] waddr, raddr;
   blk_type       wdata;

   // spare slot search over used bits
   logic [IW-1:0] spare;
   logic          spare_ok;
   always_comb begin
      spare = '0;
      spare_ok = 1'b0;
      for (int i = MAX_BLOCKS - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            spare = IW'(i);
            spare_ok = 1'b1;
         end
      end
   end

   logic [32:0] need_split;
   assign need_split = rsize_ff + 33'(HDR) + 33'd4;

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rd_ff <= mem[raddr];
   end

   always_comb begin
      state_in = state_ff; clr_in = clr_ff; base_in = base_ff; size_in = size_ff;
      op_in = op_ff; rsize_in = rsize_ff; faddr_in = faddr_ff; cur_in = cur_ff;
      nx_in = nx_ff; steps_in = steps_ff; cb_in = cb_ff; rsp_in = rsp_ff;
      res_in = res_ff; rv_in = rv_ff; used_in = used_ff;
      we = 1'b0; waddr = '0; wdata = '0; raddr = cur_ff[IW-1:0];
      if (rv_ff && rsp_tready) rv_in = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            we = 1'b1; waddr = clr_ff;
            wdata = '{start: 32'd0, length: 32'd0, free: 1'b0, succ: END_MARK};
            if (clr_ff == '0) begin
               wdata.start = base_ff;
               wdata.length = (size_ff >= HDR) ? size_ff - HDR : 32'd0;
               wdata.free = 1'b1;
            end
            if (clr_ff == IW'(MAX_BLOCKS - 1)) state_in = S_IDLE;
            else clr_in = clr_ff + 1'b1;
         end
         S_IDLE: begin
            if (req_tvalid) begin
               op_in = req_tuser;
               rsize_in = (33'(req_tdata[31:0]) + 33'd3) & ~33'd3;
               faddr_in = req_tdata[63:32];
               cur_in = '0; steps_in = '0;
               if (req_tuser == OP_ALLOC) begin
                  if (req_tdata[31:0] == 32'd0) begin
                     res_in = '{address: 32'd0, status: ST_NOMEM};
                     state_in = S_DONE;
                  end else state_in = S_AREAD;
               end else begin
                  if (req_tdata[63:32] == 32'd0) begin
                     res_in = '{address: 32'd0, status: ST_OK};
                     state_in = S_DONE;
                  end else state_in = S_FREAD;
               end
            end
         end
         S_AREAD: begin
            if (cur_ff >= END_MARK || steps_ff >= SW'(WALK_LIMIT)) begin
               res_in = '{address: 32'd0, status: ST_NOMEM};
               state_in = S_DONE;
            end else state_in = S_ACHK;
         end
         S_ACHK: begin
            if (rd_ff.free && 33'(rd_ff.length) >= rsize_ff) begin
               cb_in = rd_ff; cb_in.free = 1'b0;
               res_in = '{address: rd_ff.start + HDR, status: ST_OK};
               if (33'(rd_ff.length) >= need_split && spare_ok) begin
                  cb_in.length = rsize_ff[31:0];
                  cb_in.succ = LW'(spare);
                  // new free remainder block
                  we = 1'b1; waddr = spare;
                  wdata.start = rd_ff.start + HDR + rsize_ff[31:0];
                  wdata.length = rd_ff.length - rsize_ff[31:0] - HDR;
                  wdata.free = 1'b1;
                  wdata.succ = rd_ff.succ;
                  used_in[spare] = 1'b1;
               end
               state_in = S_SPLIT;
            end else begin
               cur_in = rd_ff.succ; steps_in = steps_ff + 1'b1;
               state_in = S_AREAD;
            end
         end
         S_SPLIT: begin
            we = 1'b1; waddr = cur_ff[IW-1:0]; wdata = cb_ff;
            state_in = S_DONE;
         end
         S_FREAD: begin
            if (cur_ff >= END_MARK || steps_ff >= SW'(WALK_LIMIT)) begin
               res_in = '{address: 32'd0, status: ST_UNKNOWN};
               state_in = S_DONE;
            end else state_in = S_FCHK;
         end
         S_FCHK: begin
            if (rd_ff.start + HDR == faddr_ff) begin
               we = 1'b1; waddr = cur_ff[IW-1:0];
               wdata = rd_ff; wdata.free = 1'b1;
               cur_in = '0; steps_in = '0;
               res_in = '{address: 32'd0, status: ST_OK};
               state_in = S_MREAD;
            end else begin
               cur_in = rd_ff.succ; steps_in = steps_ff + 1'b1;
               state_in = S_FREAD;
            end
         end
         // merge walk: read cur, then its successor
         S_MREAD: begin
            if (cur_ff >= END_MARK || steps_ff >= SW'(WALK_LIMIT)) state_in = S_DONE;
            else state_in = S_MCUR;
         end
         S_MCUR: begin
            cb_in = rd_ff; nx_in = rd_ff.succ;
            if (rd_ff.succ >= END_MARK) state_in = S_DONE;
            else begin
               raddr = rd_ff.succ[IW-1:0];
               state_in = S_MNXT;
            end
         end
         // keep the successor entry on the read port
         S_MNXT: begin
            raddr = nx_ff[IW-1:0];
            state_in = S_MCHK;
         end
         S_MCHK: begin
            steps_in = steps_ff + 1'b1;
            if (cb_ff.free && rd_ff.free) begin
               cb_in.length = cb_ff.length + HDR + rd_ff.length;
               cb_in.succ = rd_ff.succ;
               we = 1'b1; waddr = nx_ff[IW-1:0];
               wdata = '{start: 32'd0, length: 32'd0, free: 1'b0, succ: END_MARK};
               used_in[nx_ff[IW-1:0]] = 1'b0;
               state_in = S_SPLIT;
               // after writing cur back, continue from same cur
               if (steps_ff + 1'b1 >= SW'(WALK_LIMIT)) state_in = S_SPLIT;
            end else begin
               cur_in = nx_ff;
               state_in = S_MREAD;
            end
         end
         // hand the result to the output register once it is free
         S_DONE: begin
            if (!rv_ff || rsp_tready) begin
               rsp_in = res_ff;
               rv_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      // merged write-back of cur then resume merge walk
      if (state_ff == S_SPLIT && op_ff == OP_FREE) state_in = S_MREAD;
      if (csr_wen) begin
         if (csr_index == CSR_HEAP_BASE) base_in = csr_wdata;
         else size_in = csr_wdata;
         clr_in = '0; used_in = '0; used_in[0] = 1'b1;
         state_in = S_CLEAR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR; clr_ff <= '0; base_ff <= 32'd0; size_ff <= 32'd65536;
         used_ff <= MAX_BLOCKS'(1); rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in; clr_ff <= clr_in; base_ff <= base_in;
         size_ff <= size_in; used_ff <= used_in; rv_ff <= rv_in;
      end
      op_ff <= op_in; rsize_ff <= rsize_in; faddr_ff <= faddr_in; cur_ff <= cur_in;
      nx_ff <= nx_in; steps_ff <= steps_in; cb_ff <= cb_in; rsp_ff <= rsp_in;
      res_ff <= res_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rv_ff;
   assign rsp_tdata  = {6'd0, rsp_ff.status, rsp_ff.address};
endmodule
